### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that the antecedent implies the consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check that the antecedent implies the consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/hkc_pkg.sv
package hkc_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int OUT_WIDTH = 32;
	localparam int STEP_W = 4;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [1:0] {
		FUNC_DIGIT = 2'd0,
		FUNC_BACK  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_OPER  = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		OP_EQ  = 4'd0,
		OP_ADD = 4'd1,
		OP_SUB = 4'd2,
		OP_MUL = 4'd3,
		OP_AND = 4'd4,
		OP_OR  = 4'd5,
		OP_XOR = 4'd6,
		OP_SHL = 4'd7,
		OP_SHR = 4'd8,
		OP_DIV = 4'd9,
		OP_MOD = 4'd10
	} op_t;

	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_BACK,
		UOP_CLEAR,
		UOP_DIGIT,
		UOP_OPSKIP,
		UOP_SIMPLE,
		UOP_ITINIT,
		UOP_ITSTEP,
		UOP_ITDONE,
		UOP_FINISH
	} uop_t;

	typedef enum logic [3:0] {
		COND_NONE,
		COND_ALWAYS,
		COND_NOT_GO,
		COND_FUNC_BACK,
		COND_FUNC_CLEAR,
		COND_FUNC_DIGIT,
		COND_NEWNUM,
		COND_ITER_OP,
		COND_CNT_MORE,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		func_t func;
		logic  newnum;
		logic  iter_op;
		logic  cnt_more;
	} dp_status_t;

	localparam step_t ST_IDLE   = 4'd0;
	localparam step_t ST_BACK   = 4'd8;
	localparam step_t ST_CLEAR  = 4'd9;
	localparam step_t ST_DIGIT  = 4'd10;
	localparam step_t ST_OPSKIP = 4'd11;
	localparam step_t ST_ITINIT = 4'd12;
	localparam step_t ST_ITSTEP = 4'd13;
	localparam step_t ST_FINISH = 4'd15;

	function automatic ctrl_t ucode_rom(input step_t s);
		ctrl_t w;
		unique case (s)
			4'd0: w = '{UOP_NOP, COND_NOT_GO, ST_IDLE};
			4'd1: w = '{UOP_NOP, COND_FUNC_BACK, ST_BACK};
			4'd2: w = '{UOP_NOP, COND_FUNC_CLEAR, ST_CLEAR};
			4'd3: w = '{UOP_NOP, COND_FUNC_DIGIT, ST_DIGIT};
			4'd4: w = '{UOP_NOP, COND_NEWNUM, ST_OPSKIP};
			4'd5: w = '{UOP_NOP, COND_ITER_OP, ST_ITINIT};
			4'd6: w = '{UOP_SIMPLE, COND_ALWAYS, ST_FINISH};
			4'd8: w = '{UOP_BACK, COND_ALWAYS, ST_FINISH};
			4'd9: w = '{UOP_CLEAR, COND_ALWAYS, ST_FINISH};
			4'd10: w = '{UOP_DIGIT, COND_ALWAYS, ST_FINISH};
			4'd11: w = '{UOP_OPSKIP, COND_ALWAYS, ST_FINISH};
			4'd12: w = '{UOP_ITINIT, COND_NONE, ST_IDLE};
			4'd13: w = '{UOP_ITSTEP, COND_CNT_MORE, ST_ITSTEP};
			4'd14: w = '{UOP_ITDONE, COND_NONE, ST_IDLE};
			4'd15: w = '{UOP_FINISH, COND_OUT_BUSY, ST_FINISH};
			default: w = '{UOP_NOP, COND_ALWAYS, ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

### design/hkc_seq.sv
module hkc_seq import hkc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  logic       out_busy,
	input  dp_status_t status,
	output uop_t       uop,
	output logic       idle
);

	step_t step_q;
	ctrl_t ctrl;
	logic  take;

	assign ctrl = ucode_rom(step_q);
	assign uop  = ctrl.uop;
	assign idle = (step_q == ST_IDLE);

	always_comb begin
		unique case (ctrl.cond)
			COND_NONE:       take = 1'b0;
			COND_ALWAYS:     take = 1'b1;
			COND_NOT_GO:     take = !go;
			COND_FUNC_BACK:  take = (status.func == FUNC_BACK);
			COND_FUNC_CLEAR: take = (status.func == FUNC_CLEAR);
			COND_FUNC_DIGIT: take = (status.func == FUNC_DIGIT);
			COND_NEWNUM:     take = status.newnum;
			COND_ITER_OP:    take = status.iter_op;
			COND_CNT_MORE:   take = status.cnt_more;
			COND_OUT_BUSY:   take = out_busy;
			default:         take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else if (take) begin
			step_q <= ctrl.target;
		end else begin
			step_q <= step_q + 4'd1;
		end
	end

endmodule

### design/hkc_dp.sv
module hkc_dp import hkc_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load_key,
	input  func_t                  func_in,
	input  logic [3:0]             key_in,
	input  uop_t                   uop,
	output dp_status_t             status,
	output logic [VALUE_WIDTH-1:0] entry,
	output logic                   changed,
	output logic                   beep
);

	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int SHW   = $clog2(VALUE_WIDTH);

	logic [VALUE_WIDTH-1:0] entry_q, first_q, acc_q, mq_q;
	op_t                    pend_q;
	logic                   newnum_q, chg_q, beep_q;
	func_t                  func_q;
	logic [3:0]             key_q;
	logic [CNT_W-1:0]       cnt_q;

	logic [VALUE_WIDTH-1:0] simple_res, mul_next, iter_res, dig_base;
	logic [VALUE_WIDTH:0]   div_t, div_diff;
	logic                   div_ge, shift_big, is_mul;

	assign is_mul    = (pend_q == OP_MUL);
	assign shift_big = (entry_q >= VALUE_WIDTH'(VALUE_WIDTH));
	assign dig_base  = newnum_q ? '0 : entry_q;

	always_comb begin
		case (pend_q)
			OP_EQ:   simple_res = entry_q;
			OP_ADD:  simple_res = first_q + entry_q;
			OP_SUB:  simple_res = first_q - entry_q;
			OP_AND:  simple_res = first_q & entry_q;
			OP_OR:   simple_res = first_q | entry_q;
			OP_XOR:  simple_res = first_q ^ entry_q;
			OP_SHL:  simple_res = shift_big ? '0 : first_q << entry_q[SHW-1:0];
			OP_SHR:  simple_res = shift_big ? '0 : first_q >> entry_q[SHW-1:0];
			default: simple_res = '0;
		endcase
	end

	assign mul_next = {acc_q[VALUE_WIDTH-2:0], 1'b0} + (mq_q[VALUE_WIDTH-1] ? first_q : '0);
	assign div_t    = {acc_q, mq_q[VALUE_WIDTH-1]};
	assign div_diff = div_t - {1'b0, entry_q};
	assign div_ge   = !div_diff[VALUE_WIDTH];

	always_comb begin
		if (is_mul) begin
			iter_res = acc_q;
		end else if (entry_q == '0) begin
			iter_res = '1;
		end else if (pend_q == OP_DIV) begin
			iter_res = mq_q;
		end else begin
			iter_res = acc_q;
		end
	end

	assign status.func     = func_q;
	assign status.newnum   = newnum_q;
	assign status.iter_op  = is_mul || (pend_q == OP_DIV) || (pend_q == OP_MOD);
	assign status.cnt_more = (cnt_q != CNT_W'(1));

	assign entry   = entry_q;
	assign changed = chg_q;
	assign beep    = beep_q;

	always_ff @(posedge clk) begin
		if (load_key) begin
			func_q <= func_in;
			key_q  <= key_in;
		end
		if (uop == UOP_ITINIT) begin
			acc_q <= '0;
			mq_q  <= is_mul ? entry_q : first_q;
		end else if (uop == UOP_ITSTEP) begin
			if (is_mul) begin
				acc_q <= mul_next;
				mq_q  <= {mq_q[VALUE_WIDTH-2:0], 1'b0};
			end else begin
				acc_q <= div_ge ? div_diff[VALUE_WIDTH-1:0] : div_t[VALUE_WIDTH-1:0];
				mq_q  <= {mq_q[VALUE_WIDTH-2:0], div_ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q  <= '0;
			first_q  <= '0;
			pend_q   <= OP_EQ;
			newnum_q <= 1'b1;
			chg_q    <= 1'b0;
			beep_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			case (uop)
				UOP_BACK: begin
					entry_q <= entry_q >> 4;
					chg_q   <= 1'b1;
					beep_q  <= 1'b0;
				end
				UOP_CLEAR: begin
					entry_q <= '0;
					chg_q   <= 1'b1;
					beep_q  <= 1'b0;
				end
				UOP_DIGIT: begin
					if (newnum_q) begin
						first_q <= entry_q;
					end
					newnum_q <= 1'b0;
					if (dig_base[VALUE_WIDTH-1 -: 4] == 4'd0) begin
						entry_q <= {dig_base[VALUE_WIDTH-5:0], key_q};
						chg_q   <= 1'b1;
						beep_q  <= 1'b0;
					end else begin
						entry_q <= dig_base;
						chg_q   <= 1'b0;
						beep_q  <= 1'b1;
					end
				end
				UOP_OPSKIP: begin
					newnum_q <= 1'b1;
					pend_q   <= op_t'(key_q);
					chg_q    <= 1'b0;
					beep_q   <= 1'b0;
				end
				UOP_SIMPLE: begin
					entry_q  <= simple_res;
					newnum_q <= 1'b1;
					pend_q   <= op_t'(key_q);
					chg_q    <= 1'b1;
					beep_q   <= 1'b0;
				end
				UOP_ITINIT: begin
					cnt_q <= CNT_W'(VALUE_WIDTH);
				end
				UOP_ITSTEP: begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
				UOP_ITDONE: begin
					entry_q  <= iter_res;
					newnum_q <= 1'b1;
					pend_q   <= op_t'(key_q);
					chg_q    <= 1'b1;
					beep_q   <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### design/hex_key_calculator_core.sv
// channel | valid        | ready        | payload
// key     | key_valid    | key_ready    | func, key_value
// result  | result_valid | result_ready | display_value, display_changed, beep
//
// Keys without * / % are handled without the iterative loop; applying * / or % runs the
// one-bit-per-step shift-add / shift-subtract loop of the datapath before result_valid is set.
// Reset puts entry and first operand at zero, pending operator at equals, new-number set.
// key_ready is high only while the sequencer waits at its idle step; a finished result
// holds the sequencer at its last step until the result register is free.
`include "assert_macros.svh"

module hex_key_calculator_core import hkc_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 key_valid,
	output logic                 key_ready,
	input  logic [1:0]           func,
	input  logic [3:0]           key_value,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [OUT_WIDTH-1:0] display_value,
	output logic                 display_changed,
	output logic                 beep
);

	logic                   go, out_busy, out_load, idle;
	logic                   dp_changed, dp_beep;
	logic [VALUE_WIDTH-1:0] dp_entry;
	logic [63:0]            entry_wide;
	uop_t                   uop;
	dp_status_t             status;

	logic [OUT_WIDTH-1:0]   disp_q;
	logic                   rvalid_q, chg_out_q, beep_out_q;

	assign key_ready  = idle;
	assign go         = key_valid && idle;
	assign out_busy   = rvalid_q && !result_ready;
	assign out_load   = (uop == UOP_FINISH) && !out_busy;
	assign entry_wide = 64'(dp_entry);

	hkc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.out_busy (out_busy),
		.status   (status),
		.uop      (uop),
		.idle     (idle)
	);

	hkc_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.load_key(go),
		.func_in (func_t'(func)),
		.key_in  (key_value),
		.uop     (uop),
		.status  (status),
		.entry   (dp_entry),
		.changed (dp_changed),
		.beep    (dp_beep)
	);

	always_ff @(posedge clk) begin
		if (out_load) begin
			disp_q     <= entry_wide[OUT_WIDTH-1:0];
			chg_out_q  <= dp_changed;
			beep_out_q <= dp_beep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
		end else if (out_load) begin
			rvalid_q <= 1'b1;
		end else if (result_ready) begin
			rvalid_q <= 1'b0;
		end
	end

	assign result_valid    = rvalid_q;
	assign display_value   = disp_q;
	assign display_changed = chg_out_q;
	assign beep            = beep_out_q;

	`ASSERT_NEXT(a_accept_drops_ready, key_valid && key_ready, !key_ready, "ready after accept")
	`ASSERT_IMPL(a_load_when_free, out_load, !result_valid || result_ready, "result overwritten")
	`ASSERT_IMPL(a_beep_excl, result_valid, !(beep && display_changed), "beep with change")
	`ASSERT_CLK(a_valid_from_load, $rose(result_valid) |-> $past(out_load), "result without load")

endmodule

### tb/hex_key_calculator_core_tb.sv
`timescale 1ns / 100ps

module hex_key_calculator_core_tb;
	import hkc_pkg::*;

	localparam int VW = VALUE_WIDTH_DEF;
	localparam int DIRECTED_ROWS = 36;
	localparam int TOTAL_KEYS = 950;
	localparam logic [3:0] OP_UNKNOWN = 4'd11;

	typedef struct packed {
		logic [OUT_WIDTH-1:0] value;
		logic                 changed;
		logic                 beep;
	} disp_t;

	typedef struct packed {
		func_t      f;
		logic [3:0] k;
		logic       typed;
		disp_t      want;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 key_valid = 1'b0;
	logic                 key_ready;
	logic [1:0]           func = FUNC_DIGIT;
	logic [3:0]           key_value = 4'd0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic [OUT_WIDTH-1:0] display_value;
	logic                 display_changed;
	logic                 beep;

	logic [VW-1:0] calc_entry = '0;
	logic [VW-1:0] calc_operand = '0;
	logic [3:0]    calc_op = OP_EQ;
	logic          calc_fresh = 1'b1;

	disp_t pending_displays [$];
	row_t  directed [0:DIRECTED_ROWS-1];
	int    keys_sent = 0;
	int    mismatches = 0;
	logic  steady = 1'b0;

	hex_key_calculator_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.key_valid      (key_valid),
		.key_ready      (key_ready),
		.func           (func),
		.key_value      (key_value),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.display_value  (display_value),
		.display_changed(display_changed),
		.beep           (beep)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [VW-1:0] combine(logic [VW-1:0] a, logic [3:0] op,
			logic [VW-1:0] b);
		case (op)
			OP_EQ:  return b;
			OP_ADD: return a + b;
			OP_SUB: return a - b;
			OP_MUL: return a * b;
			OP_AND: return a & b;
			OP_OR:  return a | b;
			OP_XOR: return a ^ b;
			OP_SHL: return (b >= VW) ? '0 : a << b;
			OP_SHR: return (b >= VW) ? '0 : a >> b;
			OP_DIV: return (b != 0) ? a / b : '1;
			OP_MOD: return (b != 0) ? a % b : '1;
			default: return '0;
		endcase
	endfunction

	function automatic disp_t press_key(func_t f, logic [3:0] k);
		disp_t d;
		d = '0;
		case (f)
			FUNC_BACK: begin
				calc_entry = calc_entry >> 4;
				d.changed = 1'b1;
			end
			FUNC_CLEAR: begin
				calc_entry = '0;
				d.changed = 1'b1;
			end
			FUNC_DIGIT: begin
				if (calc_fresh) begin
					calc_operand = calc_entry;
					calc_entry = '0;
				end
				calc_fresh = 1'b0;
				if (calc_entry <= ({VW{1'b1}} >> 4)) begin
					calc_entry = {calc_entry[VW-5:0], k};
					d.changed = 1'b1;
				end else begin
					d.beep = 1'b1;
				end
			end
			default: begin
				if (!calc_fresh) begin
					calc_entry = combine(calc_operand, calc_op, calc_entry);
					d.changed = 1'b1;
				end
				calc_fresh = 1'b1;
				calc_op = k;
			end
		endcase
		d.value = calc_entry[OUT_WIDTH-1:0];
		return d;
	endfunction

	task automatic send_key(func_t f, logic [3:0] k, logic typed, disp_t want);
		disp_t d;
		steady = (keys_sent >= 400) && (keys_sent < 560);
		while (!steady && $urandom_range(99) < 25) begin
			key_valid <= 1'b0;
			@(posedge clk);
		end
		key_valid <= 1'b1;
		func <= f;
		key_value <= k;
		do @(posedge clk); while (!key_ready);
		d = press_key(f, k);
		pending_displays.push_back(typed ? want : d);
		keys_sent++;
	endtask

	// hold the key channel until every display update is back
	task automatic drain;
		key_valid <= 1'b0;
		do @(posedge clk); while (pending_displays.size() != 0);
	endtask

	task automatic send_random(func_t f, logic [3:0] k);
		send_key(f, k, 1'b0, '0);
	endtask

	task automatic random_keys;
		int n;
		int r;
		while (keys_sent < TOTAL_KEYS) begin
			r = $urandom_range(99);
			if (r < 3)
				drain();
			if (r < 85) begin
				if ($urandom_range(99) < 15)
					send_random(FUNC_OPER, 4'($urandom_range(0, 10)));
				n = ($urandom_range(9) < 7) ? $urandom_range(1, 2) : $urandom_range(3, 9);
				repeat (n)
					send_random(FUNC_DIGIT, 4'($urandom_range(15)));
				if ($urandom_range(99) < 10)
					send_random(FUNC_BACK, 4'($urandom_range(15)));
				if ($urandom_range(99) < 90)
					send_random(FUNC_OPER, 4'($urandom_range(0, 10)));
				else
					send_random(FUNC_OPER, 4'($urandom_range(11, 15)));
			end else begin
				send_random(func_t'($urandom_range(3)), 4'($urandom_range(15)));
			end
		end
	endtask

	task automatic note_mismatch(disp_t want, disp_t got, logic orphan);
		mismatches++;
		if (mismatches <= 10) begin
			if (orphan)
				$display("unexpected transaction: value=%h changed=%b beep=%b",
					got.value, got.changed, got.beep);
			else
				$display("mismatch: expected value=%h changed=%b beep=%b, got value=%h changed=%b beep=%b",
					want.value, want.changed, want.beep, got.value, got.changed, got.beep);
		end
	endtask

	always @(posedge clk) begin
		disp_t got;
		disp_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				got = '{display_value, display_changed, beep};
				if (pending_displays.size() == 0) begin
					note_mismatch('0, got, 1'b1);
				end else begin
					want = pending_displays.pop_front();
					if (got.value !== want.value || got.changed !== want.changed ||
							got.beep !== want.beep)
						note_mismatch(want, got, 1'b0);
				end
			end
			result_ready <= steady || ($urandom_range(99) >= 25);
		end
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int i;
		directed = '{
			'{FUNC_DIGIT, 4'hF, 1'b1, '{32'h0000000F, 1'b1, 1'b0}},
			'{FUNC_DIGIT, 4'hF, 1'b0, '0},
			'{FUNC_DIGIT, 4'hF, 1'b0, '0},
			'{FUNC_DIGIT, 4'hF, 1'b0, '0},
			'{FUNC_DIGIT, 4'hF, 1'b0, '0},
			'{FUNC_DIGIT, 4'hF, 1'b0, '0},
			'{FUNC_DIGIT, 4'hF, 1'b0, '0},
			'{FUNC_DIGIT, 4'hF, 1'b0, '0},
			'{FUNC_DIGIT, 4'h0, 1'b1, '{32'hFFFFFFFF, 1'b0, 1'b1}},
			'{FUNC_OPER, OP_ADD, 1'b1, '{32'hFFFFFFFF, 1'b1, 1'b0}},
			'{FUNC_OPER, OP_SUB, 1'b1, '{32'hFFFFFFFF, 1'b0, 1'b0}},
			'{FUNC_DIGIT, 4'h1, 1'b0, '0},
			'{FUNC_DIGIT, 4'h2, 1'b0, '0},
			'{FUNC_BACK, 4'h0, 1'b1, '{32'h00000001, 1'b1, 1'b0}},
			'{FUNC_CLEAR, 4'hF, 1'b1, '{32'h00000000, 1'b1, 1'b0}},
			'{FUNC_DIGIT, 4'h3, 1'b0, '0},
			'{FUNC_OPER, OP_MUL, 1'b0, '0},
			'{FUNC_DIGIT, 4'hF, 1'b0, '0},
			'{FUNC_OPER, OP_DIV, 1'b0, '0},
			'{FUNC_DIGIT, 4'h0, 1'b0, '0},
			'{FUNC_OPER, OP_MOD, 1'b1, '{32'hFFFFFFFF, 1'b1, 1'b0}},
			'{FUNC_DIGIT, 4'h0, 1'b0, '0},
			'{FUNC_OPER, OP_SHL, 1'b1, '{32'hFFFFFFFF, 1'b1, 1'b0}},
			'{FUNC_DIGIT, 4'h4, 1'b0, '0},
			'{FUNC_OPER, OP_SHR, 1'b0, '0},
			'{FUNC_DIGIT, 4'h2, 1'b0, '0},
			'{FUNC_DIGIT, 4'h0, 1'b0, '0},
			'{FUNC_OPER, OP_AND, 1'b1, '{32'h00000000, 1'b1, 1'b0}},
			'{FUNC_DIGIT, 4'h7, 1'b0, '0},
			'{FUNC_OPER, OP_OR, 1'b0, '0},
			'{FUNC_DIGIT, 4'h6, 1'b0, '0},
			'{FUNC_OPER, OP_XOR, 1'b0, '0},
			'{FUNC_DIGIT, 4'h3, 1'b0, '0},
			'{FUNC_OPER, OP_UNKNOWN, 1'b0, '0},
			'{FUNC_DIGIT, 4'h9, 1'b0, '0},
			'{FUNC_OPER, OP_EQ, 1'b1, '{32'h00000000, 1'b1, 1'b0}}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		for (i = 0; i < DIRECTED_ROWS; i++)
			send_key(directed[i].f, directed[i].k, directed[i].typed, directed[i].want);
		drain();
		random_keys();
		key_valid <= 1'b0;
		while (pending_displays.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && pending_displays.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
